>>> src/cdra_pkg.sv
package cdra_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int OP_W       = 3;
  localparam int POS_W      = 6;
  localparam int STAT_W     = 2;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ       = 3'd4;
  localparam logic [OP_W-1:0] OP_WRITE      = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADIDX = 2'd3;

  typedef struct packed {
    logic latch;
    logic fetch;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

>>> src/cdra_req_if.sv
interface cdra_req_if;
  logic                                 valid;
  logic                                 ready;
  logic        [cdra_pkg::OP_W-1:0]     operation;
  logic signed [cdra_pkg::POS_W-1:0]    position;
  logic        [cdra_pkg::DATA_WIDTH-1:0] value;

  modport source (output valid, operation, position, value, input ready);
  modport sink   (input valid, operation, position, value, output ready);
endinterface

>>> src/cdra_rsp_if.sv
interface cdra_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [cdra_pkg::DATA_WIDTH-1:0]   data;
  logic [cdra_pkg::STAT_W-1:0]       status;
  logic [cdra_pkg::CNT_W-1:0]        fill_count;

  modport source (output valid, data, status, fill_count, input ready);
  modport sink   (input valid, data, status, fill_count, output ready);
endinterface

>>> src/circular_deque_random_access.sv
// Circular double-ended queue with random access, DEPTH entries.
// Channels: req (sink) carries operation, position and value; rsp (source)
// returns data, status and fill_count, one item per request, in order.
// Operations: push front/back, pop front/back, read at logical index, write
// at logical index (index equal to the count appends, index -1 prepends,
// inside the filled range replaces and returns the old entry).
// Flow: an accepted request is latched, the entry store gets a registered
// read in the fetch step, and the commit step then writes the result to the
// output register. The block takes one request at a time.
// req.ready is high only while no request is in progress; the result sits
// in an output register, so the next request is taken while it waits.
// Stall: if rsp.ready is low while a result waits, a finished request holds
// in its commit step until the output register frees up.
// Reset (rst, synchronous): the queue is emptied (head, tail, count zero)
// and no result is pending. The entry store is not cleared.
module circular_deque_random_access (
  input  logic        clk,
  input  logic        rst,
  cdra_req_if.sink    req,
  cdra_rsp_if.source  rsp
);

  cdra_pkg::ctrl_cmd_t cmd;
  cdra_pkg::dp_stat_t  stat;

  cdra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdra_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_operation   (req.operation),
    .in_position    (req.position),
    .in_value       (req.value),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_data       (rsp.data),
    .out_status     (rsp.status),
    .out_fill_count (rsp.fill_count)
  );

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while another is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.fill_count <= cdra_pkg::CNT_W'(cdra_pkg::DEPTH))
    else $error("fill count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == cdra_pkg::ST_FULL
      |-> rsp.fill_count == cdra_pkg::CNT_W'(cdra_pkg::DEPTH) && rsp.data == '0)
    else $error("full status without a full queue");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == cdra_pkg::ST_EMPTY
      |-> rsp.fill_count == '0 && rsp.data == '0)
    else $error("empty status without an empty queue");
`endif

endmodule

>>> src/cdra_ctrl.sv
module cdra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cdra_pkg::dp_stat_t  stat,
  output cdra_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_FINISH} state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_FETCH;
        end
        S_FETCH: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign cmd.latch  = (state == S_IDLE) && in_valid;
  assign cmd.fetch  = (state == S_FETCH);
  assign cmd.commit = (state == S_FINISH) && stat.out_free;

endmodule

>>> src/cdra_datapath.sv
module cdra_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cdra_pkg::ctrl_cmd_t                   cmd,
  output cdra_pkg::dp_stat_t                    stat,
  input  logic        [cdra_pkg::OP_W-1:0]      in_operation,
  input  logic signed [cdra_pkg::POS_W-1:0]     in_position,
  input  logic        [cdra_pkg::DATA_WIDTH-1:0] in_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [cdra_pkg::DATA_WIDTH-1:0] out_data,
  output logic        [cdra_pkg::STAT_W-1:0]    out_status,
  output logic        [cdra_pkg::CNT_W-1:0]     out_fill_count
);

  localparam int PTR_W = cdra_pkg::PTR_W;
  localparam int CNT_W = cdra_pkg::CNT_W;
  localparam int CMP_W = cdra_pkg::CMP_W;
  localparam int DW    = cdra_pkg::DATA_WIDTH;
  localparam int POS_W = cdra_pkg::POS_W;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_POP_FRONT, ACT_POP_BACK,
    ACT_READ, ACT_REPLACE
  } act_t;

  logic [cdra_pkg::OP_W-1:0] req_op;
  logic [POS_W-1:0]          req_pos;
  logic [DW-1:0]             req_val;

  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;

  logic [DW-1:0] mem [cdra_pkg::DEPTH];
  logic [DW-1:0] rd_data;

  act_t                        act;
  logic [cdra_pkg::STAT_W-1:0] status;
  logic [PTR_W-1:0]            slot;
  logic [PTR_W-1:0]            head_inc, head_dec, tail_inc, tail_dec, pos_slot;
  logic [PTR_W+1:0]            pos_sum;
  logic                        full, empty, pos_neg, pos_minus1, pos_at_cnt, pos_in_rng;
  logic [CMP_W-1:0]            pos_mag, cnt_ext;
  logic                        wr_en, rd_used;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_op  <= in_operation;
      req_pos <= in_position;
      req_val <= in_value;
    end
  end

  assign full       = (count == CNT_W'(cdra_pkg::DEPTH));
  assign empty      = (count == '0);
  assign pos_neg    = req_pos[POS_W-1];
  assign pos_minus1 = (req_pos == '1);
  assign pos_mag    = CMP_W'(req_pos[POS_W-2:0]);
  assign cnt_ext    = CMP_W'(count);
  assign pos_at_cnt = !pos_neg && (pos_mag == cnt_ext);
  assign pos_in_rng = !pos_neg && (pos_mag < cnt_ext);

  assign head_inc = (head == PTR_W'(cdra_pkg::DEPTH - 1)) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? PTR_W'(cdra_pkg::DEPTH - 1) : head - 1'b1;
  assign tail_inc = (tail == PTR_W'(cdra_pkg::DEPTH - 1)) ? '0 : tail + 1'b1;
  assign tail_dec = (tail == '0) ? PTR_W'(cdra_pkg::DEPTH - 1) : tail - 1'b1;

  // only used when pos < count <= DEPTH, so one subtract wraps it
  assign pos_sum  = (PTR_W+2)'(head) + (PTR_W+2)'(pos_mag[CNT_W-1:0]);
  assign pos_slot = (pos_sum >= (PTR_W+2)'(cdra_pkg::DEPTH))
                  ? PTR_W'(pos_sum - (PTR_W+2)'(cdra_pkg::DEPTH)) : PTR_W'(pos_sum);

  always_comb begin
    act    = ACT_NONE;
    status = cdra_pkg::ST_OK;
    unique case (req_op)
      cdra_pkg::OP_PUSH_FRONT: begin
        if (full) status = cdra_pkg::ST_FULL;
        else      act    = ACT_PUSH_FRONT;
      end
      cdra_pkg::OP_PUSH_BACK: begin
        if (full) status = cdra_pkg::ST_FULL;
        else      act    = ACT_PUSH_BACK;
      end
      cdra_pkg::OP_POP_FRONT: begin
        if (empty) status = cdra_pkg::ST_EMPTY;
        else       act    = ACT_POP_FRONT;
      end
      cdra_pkg::OP_POP_BACK: begin
        if (empty) status = cdra_pkg::ST_EMPTY;
        else       act    = ACT_POP_BACK;
      end
      cdra_pkg::OP_READ: begin
        if (pos_in_rng) act    = ACT_READ;
        else            status = cdra_pkg::ST_BADIDX;
      end
      cdra_pkg::OP_WRITE: begin
        priority if (pos_at_cnt) begin
          if (full) status = cdra_pkg::ST_FULL;
          else      act    = ACT_PUSH_BACK;
        end else if (pos_minus1) begin
          if (full) status = cdra_pkg::ST_FULL;
          else      act    = ACT_PUSH_FRONT;
        end else if (pos_in_rng) begin
          act = ACT_REPLACE;
        end else begin
          status = cdra_pkg::ST_BADIDX;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    slot       = pos_slot;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    wr_en      = 1'b0;
    rd_used    = 1'b0;
    unique case (act)
      ACT_PUSH_FRONT: begin
        slot       = head_dec;
        head_next  = head_dec;
        count_next = count + 1'b1;
        wr_en      = 1'b1;
      end
      ACT_PUSH_BACK: begin
        slot       = tail;
        tail_next  = tail_inc;
        count_next = count + 1'b1;
        wr_en      = 1'b1;
      end
      ACT_POP_FRONT: begin
        slot       = head;
        head_next  = head_inc;
        count_next = count - 1'b1;
        rd_used    = 1'b1;
      end
      ACT_POP_BACK: begin
        slot       = tail_dec;
        tail_next  = tail_dec;
        count_next = count - 1'b1;
        rd_used    = 1'b1;
      end
      ACT_READ: begin
        rd_used = 1'b1;
      end
      ACT_REPLACE: begin
        wr_en   = 1'b1;
        rd_used = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) rd_data <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) mem[slot] <= req_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        head      <= head_next;
        tail      <= tail_next;
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data       <= rd_used ? rd_data : '0;
      out_status     <= status;
      out_fill_count <= count_next;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule
